[hdl/tcw_pkg.sv]
// Shared types and constants for the text console tile writer.
// No dependencies; every other file imports this package.
package tcw_pkg;

    // default geometry, handed to the top level parameters
    localparam int ROWS_DEF     = 14;
    localparam int COLUMNS_DEF  = 35;
    localparam int TAB_STEP_DEF = 4;

    // map layout
    localparam int ROW_STRIDE    = 128;
    localparam int BOTTOM_OFFSET = 64;
    localparam int COL_MAX       = 63;

    // field widths
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int ROW_IN_W    = 4;
    localparam int COL_W       = 6;
    localparam int RADDR_W     = 11;
    localparam int TILE_W      = 16;
    localparam int COLOUR_W    = 4;
    localparam int CODE_W      = 7;

    localparam logic [COLOUR_W-1:0] COLOUR_RESET = 4'd15;
    localparam logic [TILE_W-1:0]   TILE_BOTTOM_ADD = 16'd96;

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_FIRST = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        logic [TILE_W-1:0]   read_data;
        logic [ROW_IN_W-1:0] cursor_row;
        logic [COL_W-1:0]    cursor_column;
    } t_result;

endpackage

[hdl/tcw_if.sv]
// Valid/ready channel interfaces for the command input and the result output.
// Depends on tcw_pkg for field widths.
interface tcw_in_if;
    import tcw_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  char_code;
    logic [ROW_IN_W-1:0] row;
    logic [COL_W-1:0]   column;
    logic [RADDR_W-1:0] read_address;

    modport source (output valid, op, char_code, row, column, read_address, input ready);
    modport sink   (input valid, op, char_code, row, column, read_address, output ready);
endinterface

interface tcw_out_if;
    import tcw_pkg::*;
    logic                valid;
    logic                ready;
    logic [TILE_W-1:0]   read_data;
    logic [ROW_IN_W-1:0] cursor_row;
    logic [COL_W-1:0]    cursor_column;

    modport source (output valid, read_data, cursor_row, cursor_column, input ready);
    modport sink   (input valid, read_data, cursor_row, cursor_column, output ready);
endinterface

[hdl/tcw_map_ram.sv]
// Tile map store: one write port, one read port with registered read data.
// Depends on tcw_pkg for the tile width and default depth.
module tcw_map_ram #(
    parameter int  DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::ROW_STRIDE,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [tcw_pkg::TILE_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [tcw_pkg::TILE_W-1:0] o_rdata
);
    import tcw_pkg::*;

    logic [TILE_W-1:0] r_mem [DEPTH];
    logic [TILE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/tcw_seq.sv]
// Command sequencer: cursor state, wrap/scroll/tab stepping, and the address
// sweeps for scroll, clear and the post-reset clear. Depends on tcw_pkg.
module tcw_seq #(
    parameter int  ROWS     = tcw_pkg::ROWS_DEF,
    parameter int  COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int  TAB_STEP = tcw_pkg::TAB_STEP_DEF,
    localparam int AW       = $clog2(ROWS * tcw_pkg::ROW_STRIDE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  tcw_pkg::t_op                i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::ROW_IN_W-1:0] i_row,
    input  logic [tcw_pkg::COL_W-1:0]   i_column,
    input  logic [tcw_pkg::RADDR_W-1:0] i_read_address,
    input  logic [tcw_pkg::COLOUR_W-1:0] i_colour,
    output logic                        o_idle,
    output logic                        o_done,
    input  logic                        i_take,
    output tcw_pkg::t_result            o_result,
    output logic                        o_ram_we,
    output logic [AW-1:0]               o_ram_waddr,
    output logic [tcw_pkg::TILE_W-1:0]  o_ram_wdata,
    output logic [AW-1:0]               o_ram_raddr,
    input  logic [tcw_pkg::TILE_W-1:0]  i_ram_rdata
);
    import tcw_pkg::*;

    localparam int DEPTH     = ROWS * ROW_STRIDE;
    localparam int RW        = $clog2(ROWS + 1);
    localparam int LAST_BASE = (ROWS - 1) * ROW_STRIDE;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PUT   = 10'b0000000010,
        S_CHAR  = 10'b0000000100,
        S_BOT   = 10'b0000001000,
        S_TAB   = 10'b0000010000,
        S_COPY  = 10'b0000100000,
        S_CPEND = 10'b0001000000,
        S_FILL  = 10'b0010000000,
        S_RD    = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state             r_state, n_state;
    logic [RW-1:0]      r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [AW-1:0]      r_cpa, n_cpa;
    logic               r_cp_pend, n_cp_pend;
    logic               r_init, n_init;
    logic [COL_W:0]     r_acc, n_acc;
    logic [TILE_W-1:0]  r_tile, n_tile;
    logic [CHAR_W-1:0]  r_char, n_char;
    t_op                r_op, n_op;
    logic [TILE_W-1:0]  r_rd, n_rd;
    logic               r_oob, n_oob;

    logic               in_oob;
    logic [RW-1:0]      wrap_row;
    logic [COL_W-1:0]   wrap_col;
    logic [AW-1:0]      top_addr;
    logic [AW-1:0]      bot_addr;
    logic [TILE_W-1:0]  tile_top;
    logic               printable;

    assign in_oob   = {1'b0, i_read_address} >= (RADDR_W + 1)'(DEPTH);
    assign wrap_row = (r_col >= COL_W'(COLUMNS)) ? r_row + RW'(1) : r_row;
    assign wrap_col = (r_col >= COL_W'(COLUMNS)) ? '0 : r_col;
    assign top_addr = AW'({r_row, 7'(r_col)});
    assign bot_addr = AW'({r_row, 7'(r_col) + 7'(BOTTOM_OFFSET)});
    assign tile_top = {i_colour, 5'b0, CODE_W'(r_char - CH_FIRST)};
    assign printable = (r_char >= CH_FIRST) && (r_char <= CH_LAST);

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_ptr     = r_ptr;
        n_cpa     = r_cpa;
        n_cp_pend = r_cp_pend;
        n_init    = r_init;
        n_acc     = r_acc;
        n_tile    = r_tile;
        n_char    = r_char;
        n_op      = r_op;
        n_rd      = r_rd;
        n_oob     = r_oob;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_ptr;
        o_ram_wdata = '0;
        o_ram_raddr = (r_state == S_COPY) ? r_ptr :
                      (in_oob ? '0 : i_read_address[AW-1:0]);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op   = i_op;
                    n_char = i_char_code;
                    n_rd   = '0;
                    n_oob  = in_oob;
                    unique case (i_op)
                        OP_PUT: n_state = S_PUT;
                        OP_SET: begin
                            n_row = ({1'b0, i_row} > (ROW_IN_W + 1)'(ROWS - 1)) ?
                                    RW'(ROWS - 1) : RW'(i_row);
                            n_col = (i_column > COL_W'(COLUMNS - 1)) ?
                                    COL_W'(COLUMNS - 1) : i_column;
                            n_state = S_DONE;
                        end
                        OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_ptr   = '0;
                            n_state = S_FILL;
                        end
                        OP_READ: n_state = S_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_PUT: begin
                n_row = wrap_row;
                n_col = wrap_col;
                if (wrap_row >= RW'(ROWS)) begin
                    n_row = RW'(ROWS - 1);
                    if (ROWS > 1) begin
                        n_ptr     = AW'(ROW_STRIDE);
                        n_cp_pend = 1'b0;
                        n_state   = S_COPY;
                    end else begin
                        n_ptr   = AW'(LAST_BASE);
                        n_state = S_FILL;
                    end
                end else begin
                    n_state = S_CHAR;
                end
            end
            S_COPY: begin
                // read one row ahead, write the previous read back a row up
                o_ram_we    = r_cp_pend;
                o_ram_waddr = r_cpa;
                o_ram_wdata = i_ram_rdata;
                n_cpa       = r_ptr - AW'(ROW_STRIDE);
                n_cp_pend   = 1'b1;
                if (r_ptr == AW'(DEPTH - 1)) begin
                    n_state = S_CPEND;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_CPEND: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_cpa;
                o_ram_wdata = i_ram_rdata;
                n_cp_pend   = 1'b0;
                n_ptr       = AW'(LAST_BASE);
                n_state     = S_FILL;
            end
            S_FILL: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_ptr;
                o_ram_wdata = '0;
                if (r_ptr == AW'(DEPTH - 1)) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else if (r_op == OP_PUT) begin
                        n_state = S_CHAR;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_CHAR: begin
                priority if (r_char == CH_TAB) begin
                    n_acc   = (COL_W + 1)'(TAB_STEP);
                    n_state = S_TAB;
                end else if (r_char == CH_LF) begin
                    n_row   = r_row + RW'(1);
                    n_col   = '0;
                    n_state = S_DONE;
                end else if (r_char == CH_CR) begin
                    n_col   = '0;
                    n_state = S_DONE;
                end else if (printable) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = top_addr;
                    o_ram_wdata = tile_top;
                    n_tile      = tile_top;
                    n_state     = S_BOT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BOT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = bot_addr;
                o_ram_wdata = r_tile + TILE_BOTTOM_ADD;
                n_col       = r_col + COL_W'(1);
                n_state     = S_DONE;
            end
            S_TAB: begin
                // step up by the tab width until past the cursor
                if (r_acc > {1'b0, r_col}) begin
                    n_col   = (r_acc > (COL_W + 1)'(COL_MAX)) ? COL_W'(COL_MAX)
                                                              : r_acc[COL_W-1:0];
                    n_state = S_DONE;
                end else begin
                    n_acc = r_acc + (COL_W + 1)'(TAB_STEP);
                end
            end
            S_RD: begin
                n_rd    = r_oob ? '0 : i_ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_row     <= '0;
            r_col     <= '0;
            r_ptr     <= '0;
            r_cp_pend <= 1'b0;
            r_init    <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_ptr     <= n_ptr;
            r_cp_pend <= n_cp_pend;
            r_init    <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cpa  <= n_cpa;
        r_acc  <= n_acc;
        r_tile <= n_tile;
        r_char <= n_char;
        r_op   <= n_op;
        r_rd   <= n_rd;
        r_oob  <= n_oob;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);

    assign o_result.read_data     = r_rd;
    assign o_result.cursor_row    = ROW_IN_W'(r_row);
    assign o_result.cursor_column = r_col;

endmodule

[hdl/text_console_tile_writer.sv]
// Text console tile writer. A put past the last row scrolls the map up one row and blanks
// the last row before the character is handled; clear blanks the whole map. A tab steps the
// column up by the tab width until it passes the cursor. The next command is accepted the
// cycle after a result is loaded. Reset clears all ROWS*128 map entries with no command
// accepted; the colour register is writable meanwhile.
module text_console_tile_writer #(
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tcw_in_if.sink                       i_in,
    tcw_out_if.source                    o_res,
    input  logic                         i_cfg_we,
    input  logic [tcw_pkg::COLOUR_W-1:0] i_cfg_wdata
);
    import tcw_pkg::*;

    localparam int DEPTH = ROWS * ROW_STRIDE;
    localparam int AW    = $clog2(DEPTH);

    logic [COLOUR_W-1:0] r_colour;
    logic                r_ovalid;
    t_result             r_res;

    logic                seq_idle;
    logic                seq_done;
    logic                take;
    t_result             seq_result;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [TILE_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [TILE_W-1:0]   ram_rdata;

    assign i_in.ready = seq_idle;
    assign take       = seq_done && (!r_ovalid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour <= COLOUR_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_colour <= i_cfg_wdata;
            end
            // hold the result until the sink takes it
            if (take) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= seq_result;
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.read_data     = r_res.read_data;
    assign o_res.cursor_row    = r_res.cursor_row;
    assign o_res.cursor_column = r_res.cursor_column;

    tcw_seq #(
        .ROWS     (ROWS),
        .COLUMNS  (COLUMNS),
        .TAB_STEP (TAB_STEP)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_in.valid && seq_idle),
        .i_op           (t_op'(i_in.op)),
        .i_char_code    (i_in.char_code),
        .i_row          (i_in.row),
        .i_column       (i_in.column),
        .i_read_address (i_in.read_address),
        .i_colour       (r_colour),
        .o_idle         (seq_idle),
        .o_done         (seq_done),
        .i_take         (take),
        .o_result       (seq_result),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

    tcw_map_ram #(
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

[dv/tb_text_console_tile_writer.sv]
// Self-checking testbench for text_console_tile_writer: drives commands on the input channel
// and predicts every result in a scoreboard class that keeps its own tile map and cursor.
// Depends on tcw_pkg, the tcw_in_if/tcw_out_if interfaces and the text_console_tile_writer RTL.
module tb_text_console_tile_writer;
    import tcw_pkg::*;

    localparam int ROWS            = ROWS_DEF;
    localparam int COLUMNS         = COLUMNS_DEF;
    localparam int TAB_STEP        = TAB_STEP_DEF;
    localparam int MAP_DEPTH       = ROWS * ROW_STRIDE;
    localparam int CYCLE_LIMIT     = 20_000_000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_MAX      = 10;

    typedef struct {
        t_op                 op;
        logic [CHAR_W-1:0]   char_code;
        logic [ROW_IN_W-1:0] row;
        logic [COL_W-1:0]    column;
        logic [RADDR_W-1:0]  read_address;
    } t_console_cmd;

    class t_console_scoreboard;
        logic [TILE_W-1:0]   tile_map [MAP_DEPTH];
        int unsigned         cur_row;
        int unsigned         cur_col;
        logic [COLOUR_W-1:0] colour;
        t_result             cursor_reports [$];
        int                  mismatches;

        function new();
            foreach (tile_map[j]) tile_map[j] = '0;
            cur_row    = 0;
            cur_col    = 0;
            colour     = COLOUR_RESET;
            mismatches = 0;
        endfunction

        // Apply one accepted command to the console copy and queue the result it causes.
        function void advance_console(t_console_cmd c);
            t_result           r;
            int unsigned       base;
            int unsigned       n;
            int unsigned       i;
            logic [TILE_W-1:0] t;
            r = '0;
            case (c.op)
                OP_PUT: begin
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                    if (cur_row >= ROWS) begin
                        // scroll up one row, blank the last one
                        for (i = 0; i + ROW_STRIDE < MAP_DEPTH; i++)
                            tile_map[i] = tile_map[i + ROW_STRIDE];
                        for (i = (ROWS - 1) * ROW_STRIDE; i < MAP_DEPTH; i++)
                            tile_map[i] = '0;
                        cur_row = ROWS - 1;
                    end
                    if (c.char_code == CH_TAB) begin
                        n = (cur_col / TAB_STEP + 1) * TAB_STEP;
                        cur_col = (n > COL_MAX) ? COL_MAX : n;
                    end else if (c.char_code == CH_LF) begin
                        cur_row++;
                        cur_col = 0;
                    end else if (c.char_code == CH_CR) begin
                        cur_col = 0;
                    end else if (c.char_code >= CH_FIRST && c.char_code <= CH_LAST) begin
                        base = cur_row * ROW_STRIDE + cur_col;
                        t = {colour, 5'b0, 7'(c.char_code - CH_FIRST)};
                        if (base < MAP_DEPTH)
                            tile_map[base] = t;
                        if (base + BOTTOM_OFFSET < MAP_DEPTH)
                            tile_map[base + BOTTOM_OFFSET] = t + TILE_BOTTOM_ADD;
                        cur_col++;
                    end
                end
                OP_SET: begin
                    cur_row = (c.row > ROWS - 1) ? ROWS - 1 : c.row;
                    cur_col = (c.column > COLUMNS - 1) ? COLUMNS - 1 : c.column;
                end
                OP_CLEAR: begin
                    foreach (tile_map[j]) tile_map[j] = '0;
                    cur_row = 0;
                    cur_col = 0;
                end
                default: begin
                    if (c.read_address < MAP_DEPTH)
                        r.read_data = tile_map[c.read_address];
                end
            endcase
            r.cursor_row    = cur_row[ROW_IN_W-1:0];
            r.cursor_column = cur_col[COL_W-1:0];
            cursor_reports.push_back(r);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch: %s", msg);
        endfunction

        function void check_report(t_result got);
            t_result want;
            if (cursor_reports.size() == 0) begin
                note_mismatch($sformatf("unexpected result data %h row %0d col %0d",
                    got.read_data, got.cursor_row, got.cursor_column));
                return;
            end
            want = cursor_reports.pop_front();
            if (got.read_data !== want.read_data)
                note_mismatch($sformatf("read_data exp %h got %h",
                    want.read_data, got.read_data));
            if (got.cursor_row !== want.cursor_row)
                note_mismatch($sformatf("cursor_row exp %0d got %0d",
                    want.cursor_row, got.cursor_row));
            if (got.cursor_column !== want.cursor_column)
                note_mismatch($sformatf("cursor_column exp %0d got %0d",
                    want.cursor_column, got.cursor_column));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [COLOUR_W-1:0] cfg_wdata = '0;
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    int                  hold_left = 0;
    int unsigned         cycle_count = 0;
    t_console_scoreboard sb;

    tcw_in_if  cmd_bus ();
    tcw_out_if res_bus ();

    text_console_tile_writer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (cmd_bus),
        .o_res       (res_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // result side: a long hold-off when asked, random stalls otherwise
    always @(negedge clk) begin
        if (hold_left > 0) begin
            res_bus.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            res_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            sb.check_report({res_bus.read_data, res_bus.cursor_row, res_bus.cursor_column});
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_console_cmd cmd_of(t_op op, logic [CHAR_W-1:0] ch,
                                            logic [ROW_IN_W-1:0] r, logic [COL_W-1:0] col,
                                            logic [RADDR_W-1:0] addr);
        t_console_cmd c;
        c.op           = op;
        c.char_code    = ch;
        c.row          = r;
        c.column       = col;
        c.read_address = addr;
        return c;
    endfunction

    task automatic offer_command(t_console_cmd c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge clk);
            cmd_bus.valid <= 1'b0;
        end
        @(negedge clk);
        cmd_bus.valid        <= 1'b1;
        cmd_bus.op           <= c.op;
        cmd_bus.char_code    <= c.char_code;
        cmd_bus.row          <= c.row;
        cmd_bus.column       <= c.column;
        cmd_bus.read_address <= c.read_address;
        do @(posedge clk); while (cmd_bus.ready !== 1'b1);
        sb.advance_console(c);
    endtask

    // drop valid, then wait for every outstanding result and let the block settle
    task automatic wait_drained();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (sb.cursor_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_colour(logic [COLOUR_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.colour = v;
    endtask

    task automatic run_random_phase(int count);
        t_console_cmd c;
        int           pick;
        for (int k = 0; k < count; k++) begin
            pick           = $urandom_range(0, 999);
            c.char_code    = 8'($urandom);
            c.row          = 4'($urandom);
            c.column       = 6'($urandom);
            c.read_address = 11'($urandom);
            if (pick < 700) begin
                c.op = OP_PUT;
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    c.char_code = 8'($urandom_range(CH_FIRST, CH_LAST));
                else if (pick < 71)
                    c.char_code = CH_LF;
                else if (pick < 75)
                    c.char_code = CH_CR;
                else if (pick < 85)
                    c.char_code = CH_TAB;
                // else keep the full-range byte
            end else if (pick < 820) begin
                c.op = OP_SET;
                if ($urandom_range(0, 99) < 70) begin
                    c.row    = 4'($urandom_range(0, ROWS - 1));
                    c.column = 6'($urandom_range(0, COLUMNS - 1));
                end
            end else if (pick < 835) begin
                c.op = OP_CLEAR;
            end else begin
                c.op = OP_READ;
                pick = $urandom_range(0, 99);
                // half the time read back tiles just written next to the cursor
                if (pick < 50)
                    c.read_address = 11'(sb.cur_row * ROW_STRIDE + sb.cur_col - 1
                                         + $urandom_range(0, 1) * BOTTOM_OFFSET);
                else if (pick < 80)
                    c.read_address = 11'($urandom_range(0, MAP_DEPTH - 1));
            end
            offer_command(c);
        end
    endtask

    initial begin
        sb = new();
        cmd_bus.valid        = 1'b0;
        cmd_bus.op           = OP_PUT;
        cmd_bus.char_code    = '0;
        cmd_bus.row          = '0;
        cmd_bus.column       = '0;
        cmd_bus.read_address = '0;
        res_bus.ready        = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 23;
        rx_idle_pct = 78;
        // directed: printable extremes, controls, ignored bytes, saturation, wrap and scroll
        offer_command(cmd_of(OP_READ, 8'h00, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_PUT, 8'h41, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_PUT, CH_FIRST, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_PUT, CH_LAST, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_READ, 8'h00, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_READ, 8'h00, 4'd0, 6'd0, 11'd64));
        offer_command(cmd_of(OP_PUT, CH_TAB, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_PUT, 8'h00, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_PUT, 8'hFF, 4'd15, 6'd63, 11'd2047));
        offer_command(cmd_of(OP_PUT, CH_CR, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_PUT, CH_LF, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_SET, 8'h00, 4'd15, 6'd63, 11'd0));
        offer_command(cmd_of(OP_PUT, 8'h7E, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_PUT, 8'h21, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_READ, 8'h00, 4'd0, 6'd0, 11'(12 * ROW_STRIDE + 34)));
        offer_command(cmd_of(OP_READ, 8'h00, 4'd0, 6'd0, 11'(12 * ROW_STRIDE + 98)));
        offer_command(cmd_of(OP_SET, 8'h00, 4'd13, 6'd34, 11'd0));
        offer_command(cmd_of(OP_PUT, CH_TAB, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_PUT, CH_LF, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_PUT, 8'h01, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_READ, 8'h00, 4'd0, 6'd0, 11'(MAP_DEPTH - 1)));
        offer_command(cmd_of(OP_READ, 8'h00, 4'd0, 6'd0, 11'(MAP_DEPTH)));
        offer_command(cmd_of(OP_READ, 8'h00, 4'd0, 6'd0, 11'd2047));
        offer_command(cmd_of(OP_CLEAR, 8'h00, 4'd0, 6'd0, 11'd0));
        offer_command(cmd_of(OP_READ, 8'h00, 4'd0, 6'd0, 11'(12 * ROW_STRIDE + 34)));
        wait_drained();

        write_colour('0);
        run_random_phase(600);
        wait_drained();

        tx_idle_pct = 78;
        rx_idle_pct = 23;
        write_colour(COLOUR_W'($urandom_range(1, 14)));
        run_random_phase(600);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_colour(COLOUR_RESET);
        // hold off results while commands keep coming so the block backs up
        @(posedge clk);
        hold_left = HOLD_OFF_CYCLES;
        run_random_phase(480);
        wait_drained();

        if (sb.mismatches == 0 && sb.cursor_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
